[src/tga_pkg.sv]
// Package for the TGA pixel stream decoder: phase codes, register indexes,
// controller/datapath command and status structs. No dependencies.
package tga_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned PalAddrW = $clog2(PaletteDepth);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PALETTE = 2'd1,
    PH_HEADER  = 2'd2,
    PH_DATA    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_READ = 3'd1,
    ST_WAIT = 3'd2,
    ST_EMIT = 3'd3
  } ctrl_state_e;

  localparam logic [2:0] RegImageType  = 3'd0;
  localparam logic [2:0] RegHasMap     = 3'd1;
  localparam logic [2:0] RegPalEntries = 3'd2;
  localparam logic [2:0] RegEntryBits  = 3'd3;
  localparam logic [2:0] RegPixelBits  = 3'd4;
  localparam logic [2:0] RegWidth      = 3'd5;
  localparam logic [2:0] RegHeight     = 3'd6;
  localparam logic [2:0] RegTopOrigin  = 3'd7;

  // Controller to datapath.
  typedef struct packed {
    logic take_byte;   // consume the input beat
    logic lookup;      // start palette read of the assembled index
    logic latch_col;   // capture resolved colour, start pixel output
    logic emit_span;   // load output register with one span
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_lookup; // the beat finishes a colour-mapped pixel element
    logic pixels_left; // pending pixels of the current element
    logic out_full;    // output register holds an undelivered beat
    logic span_last;   // the next span is the last one of the element
  } dp_stat_t;

endpackage

[src/tga_pixel_stream_decoder.sv]
// Top level of the TGA pixel stream decoder: joins the controller and datapath.
// Depends on tga_pkg, tga_ctrl, tga_dp.
//
// A true-colour byte that ends a pixel element yields the element's first span
// in the cycle it is taken. A colour-mapped element holds the input through
// the states READ and WAIT for the registered palette read and EMIT for its
// first span. Each further span of a run packet that crosses rows comes from
// EMIT, and any span waits while the output register is stalled. No clearing
// pass follows reset.
module tga_pixel_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_image_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [7:0]  span_length_o,
  output logic [31:0] colour_o,
  output logic        status_o,
  output logic        last_of_run_o,
  output logic        end_of_image_o
);
  import tga_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tga_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .stat_i(stat), .in_stall_o, .cmd_o(cmd)
  );

  tga_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .data_byte_i,
    .start_of_image_i, .out_stall_i, .cmd_i(cmd), .stat_o(stat), .out_valid_o,
    .pixel_x_o, .pixel_y_o, .span_length_o, .colour_o, .status_o,
    .last_of_run_o, .end_of_image_o
  );
endmodule

[src/tga_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tga_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/tga_ctrl.sv]
// Controller of the TGA decoder: sequences byte intake, palette reads and span output.
// Depends on tga_pkg.
module tga_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tga_pkg::dp_stat_t stat_i,
  output logic              in_stall_o,
  output tga_pkg::dp_cmd_t  cmd_o
);
  import tga_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && stat_i.need_lookup) begin
          state_d = ST_READ;
        end else if (in_valid_i && stat_i.pixels_left && !stat_i.out_full
                     && !stat_i.span_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: state_d = stat_i.pixels_left ? ST_EMIT : ST_RUN;
      ST_EMIT: begin
        if (!stat_i.out_full && stat_i.span_last) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_RUN: begin
        // A beat that yields a result needs a free output register.
        in_stall_o = stat_i.pixels_left && stat_i.out_full;
        cmd_o.take_byte = in_valid_i && !in_stall_o;
        cmd_o.lookup = cmd_o.take_byte && stat_i.need_lookup;
        cmd_o.emit_span = cmd_o.take_byte && stat_i.pixels_left;
      end
      ST_READ: ;
      ST_WAIT: cmd_o.latch_col = 1'b1;
      ST_EMIT: cmd_o.emit_span = !stat_i.out_full;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_take_outside_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |-> !cmd_o.take_byte) else $error("byte taken while busy");
  a_read_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_WAIT) else $error("read sequence broken");
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_span |-> !stat_i.out_full) else $error("span over full register");
`endif
endmodule

[src/tga_dp.sv]
// Datapath of the TGA decoder: registers, byte assembly, palette, cursor, spans.
// Depends on tga_pkg and tga_ram.
module tga_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_image_i,
  input  logic              out_stall_i,
  input  tga_pkg::dp_cmd_t  cmd_i,
  output tga_pkg::dp_stat_t stat_o,
  output logic              out_valid_o,
  output logic [15:0]       pixel_x_o,
  output logic [15:0]       pixel_y_o,
  output logic [7:0]        span_length_o,
  output logic [31:0]       colour_o,
  output logic              status_o,
  output logic              last_of_run_o,
  output logic              end_of_image_o
);
  import tga_pkg::*;

  logic [7:0]  type_q;
  logic        has_map_q, top_q;
  logic [15:0] pal_n_q, width_q, height_q;
  logic [5:0]  ebits_q, pbits_q;

  phase_e      phase_q, phase_d;
  logic [15:0] load_q, load_d;
  logic [31:0] asm_q, asm_d;
  logic [1:0]  bph_q, bph_d;
  logic [7:0]  rem_q, rem_d;
  logic        run_q, run_d;
  logic [15:0] cx_q, cy_q;
  logic        done_q;

  // Pending pixel output of one element.
  logic [7:0]  cnt_q;
  logic [31:0] col_q, word_q;
  logic        err_q;  // pending error beat
  logic        oob_q;

  logic mapped, rle;
  logic [2:0] map_bytes, elem_bytes;
  assign mapped = type_q == 8'd1 || type_q == 8'd9;
  assign rle    = type_q == 8'd9 || type_q == 8'd10;
  assign map_bytes  = 3'((ebits_q + 6'd7) >> 3);
  assign elem_bytes = pbits_q[5:3];

  logic fmt_ok;
  always_comb begin
    fmt_ok = 1'b0;
    if (width_q >= 16'd3) begin
      if (mapped) begin
        fmt_ok = has_map_q && (ebits_q == 6'd24 || ebits_q == 6'd32)
                 && (pbits_q == 6'd8 || pbits_q == 6'd16);
      end else if (type_q == 8'd2 || type_q == 8'd10) begin
        fmt_ok = !(has_map_q && ebits_q > 6'd32) && (pbits_q == 6'd24 || pbits_q == 6'd32);
      end
    end
  end

  // Byte processing, the start byte restarting the state first.
  logic        elem_done, pal_we;
  logic [31:0] asm_or, pal_wdata;
  logic [7:0]  count_new;
  logic        err_new, start_ok;
  phase_e      ph_eff;
  logic [1:0]  bph_eff;
  logic [31:0] asm_eff;
  logic [15:0] load_eff;
  logic [15:0] load_inc;

  always_comb begin
    ph_eff = phase_q; bph_eff = bph_q; asm_eff = asm_q; load_eff = load_q;
    err_new = 1'b0; start_ok = 1'b0;
    if (start_of_image_i) begin
      bph_eff = '0; asm_eff = '0; load_eff = '0;
      if (!fmt_ok) begin
        err_new = 1'b1; ph_eff = PH_IDLE;
      end else if (height_q == 16'd0) begin
        ph_eff = PH_IDLE;
      end else begin
        start_ok = 1'b1;
        if (has_map_q && pal_n_q != 16'd0 && map_bytes != 3'd0) ph_eff = PH_PALETTE;
        else ph_eff = rle ? PH_HEADER : PH_DATA;
      end
    end
    asm_or = asm_eff | (32'(data_byte_i) << {bph_eff, 3'b000});
    load_inc = load_eff + 16'd1;
    phase_d = ph_eff; bph_d = bph_eff; asm_d = asm_eff; load_d = load_eff;
    rem_d = rem_q; run_d = run_q;
    if (start_of_image_i) begin rem_d = '0; run_d = 1'b0; end
    elem_done = 1'b0; pal_we = 1'b0; pal_wdata = asm_or; count_new = '0;
    unique case (ph_eff)
      PH_PALETTE: begin
        if (3'(bph_eff) + 3'd1 >= map_bytes) begin
          pal_we = load_eff < 16'(PaletteDepth);
          load_d = load_inc; asm_d = '0; bph_d = '0;
          if (load_inc >= pal_n_q) phase_d = rle ? PH_HEADER : PH_DATA;
        end else begin
          asm_d = asm_or; bph_d = bph_eff + 2'd1;
        end
      end
      PH_HEADER: begin
        run_d = data_byte_i[7];
        rem_d = {1'b0, data_byte_i[6:0]} + 8'd1;
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        if (3'(bph_eff) + 3'd1 >= elem_bytes) begin
          elem_done = 1'b1; asm_d = '0; bph_d = '0;
          if (!rle) begin
            count_new = 8'd1;
          end else if (run_q && !start_of_image_i || run_d && start_of_image_i) begin
            count_new = rem_d; rem_d = '0; phase_d = PH_HEADER;
          end else begin
            count_new = 8'd1;
            rem_d = rem_d != 8'd0 ? rem_d - 8'd1 : 8'd0;
            if (rem_d == 8'd0) phase_d = PH_HEADER;
          end
        end else begin
          asm_d = asm_or; bph_d = bph_eff + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Pixels to lay out now: those of the element taken in this cycle, if any.
  logic [7:0] cnt_cur;
  assign cnt_cur = cmd_i.take_byte && elem_done ? count_new : cnt_q;

  // Palette memory.
  logic [31:0] pal_rdata;
  logic [PalAddrW-1:0] raddr;
  logic [15:0] idx;
  assign idx = pbits_q == 6'd8 ? {8'd0, word_q[7:0]} : word_q[15:0];
  assign raddr = idx[PalAddrW-1:0];

  tga_ram #(.Width(32), .Depth(PaletteDepth)) u_pal (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take_byte && pal_we),
    .waddr_i (load_eff[PalAddrW-1:0]),
    .wdata_i (pal_wdata),
    .raddr_i (raddr),
    .rdata_o (pal_rdata)
  );

  logic [31:0] resolved;
  always_comb begin
    if (mapped) begin
      resolved = oob_q ? 32'd0 : pal_rdata;
      if (ebits_q == 6'd24) resolved = resolved & 32'h00FF_FFFF;
    end else begin
      resolved = pbits_q == 6'd24 ? (word_q & 32'h00FF_FFFF) : word_q;
    end
  end

  // Span generation from the cursor.
  logic [15:0] room;
  logic [7:0]  len;
  logic        row_end, last_row;
  logic [16:0] xend;
  always_comb begin
    room = cx_q < width_q ? width_q - cx_q : 16'd1;
    len = 16'(cnt_cur) < room ? cnt_cur : room[7:0];
    xend = {1'b0, cx_q} + 17'(len);
    row_end = xend >= {1'b0, width_q};
    last_row = top_q ? ({1'b0, cy_q} + 17'd1 >= {1'b0, height_q}) : cy_q == 16'd0;
  end

  logic pend;
  assign pend = err_q || (cnt_q != 8'd0 && !done_q);
  logic now_pixels;
  // A raw or true-colour element emits in the cycle it completes.
  assign now_pixels = elem_done && !mapped && count_new != 8'd0 && !done_q
                      || err_new;

  assign stat_o.need_lookup = mapped && elem_done && !done_q && !start_of_image_i
                              || mapped && elem_done && start_ok;
  assign stat_o.pixels_left = pend || (now_pixels && !stat_o.need_lookup);
  assign stat_o.out_full = out_valid_o && out_stall_i;
  assign stat_o.span_last = err_q || cnt_cur == len || (row_end && last_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= '0; has_map_q <= 1'b0; pal_n_q <= '0; ebits_q <= 6'd24;
      pbits_q <= 6'd24; width_q <= '0; height_q <= '0; top_q <= 1'b0;
      phase_q <= PH_IDLE; load_q <= '0; asm_q <= '0; bph_q <= '0;
      rem_q <= '0; run_q <= 1'b0; cx_q <= '0; cy_q <= '0; done_q <= 1'b0;
      cnt_q <= '0; err_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegImageType:  type_q <= cfg_data_i[7:0];
          RegHasMap:     has_map_q <= cfg_data_i[0];
          RegPalEntries: pal_n_q <= cfg_data_i;
          RegEntryBits:  ebits_q <= cfg_data_i[5:0];
          RegPixelBits:  pbits_q <= cfg_data_i[5:0];
          RegWidth:      width_q <= cfg_data_i;
          RegHeight:     height_q <= cfg_data_i;
          RegTopOrigin:  top_q <= cfg_data_i[0];
          default: ;
        endcase
        if (phase_q != PH_IDLE) done_q <= 1'b1;
        phase_q <= PH_IDLE;
      end
      if (cmd_i.take_byte) begin
        phase_q <= phase_d; bph_q <= bph_d; asm_q <= asm_d; load_q <= load_d;
        rem_q <= rem_d; run_q <= run_d;
        if (start_of_image_i) begin
          cx_q <= '0;
          done_q <= !start_ok;
          if (start_ok) cy_q <= top_q ? 16'd0 : height_q - 16'd1;
          err_q <= err_new;
        end
        if (elem_done) begin
          word_q <= asm_or;
          cnt_q <= count_new;
          col_q <= resolved;
          if (!mapped) col_q <= pbits_q == 6'd24 ? (asm_or & 32'h00FF_FFFF) : asm_or;
        end
      end
      // The index is the element assembled in this cycle.
      if (cmd_i.lookup) begin
        oob_q <= (pbits_q == 6'd8 ? {8'd0, asm_or[7:0]} : asm_or[15:0])
                 >= 16'(PaletteDepth);
      end
      if (cmd_i.latch_col) col_q <= resolved;
      if (cmd_i.emit_span) begin
        out_valid_o <= 1'b1;
        if (err_q || (cmd_i.take_byte && err_new)) begin
          err_q <= 1'b0;
          pixel_x_o <= '0; pixel_y_o <= '0; span_length_o <= '0; colour_o <= '0;
          status_o <= 1'b1; last_of_run_o <= 1'b1; end_of_image_o <= 1'b0;
        end else begin
          pixel_x_o <= cx_q; pixel_y_o <= cy_q; span_length_o <= len;
          colour_o <= cmd_i.take_byte ? (pbits_q == 6'd24 ? (asm_or & 32'h00FF_FFFF)
                                                           : asm_or) : col_q;
          status_o <= 1'b0;
          last_of_run_o <= stat_o.span_last;
          end_of_image_o <= row_end && last_row;
          cnt_q <= cnt_q - len;
          if (cmd_i.take_byte) cnt_q <= count_new - len;
          if (row_end) begin
            cx_q <= '0;
            if (last_row) begin
              done_q <= 1'b1; phase_q <= PH_IDLE; cnt_q <= '0;
            end else if (top_q) cy_q <= cy_q + 16'd1;
            else cy_q <= cy_q - 16'd1;
          end else begin
            cx_q <= xend[15:0];
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> span_length_o != 8'd0 && span_length_o <= 8'd128)
    else $error("bad span length");
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> span_length_o == 8'd0 && last_of_run_o)
    else $error("bad error beat");
  a_eoi_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_span && !err_q && row_end && last_row && !cfg_we_i |=> done_q)
    else $error("image not closed");
`endif
endmodule
